// ===== rtl/core/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkd_pkg: shared types and constants for the multi-key debouncer
// Field widths, register codes, reset values and the per-key phase type.
// ----------------------------------------------------------------------------
package mkd_pkg;

    // key count default and the key width of the stream fields
    localparam int NUM_KEYS_DEF = 3;
    localparam int FIELD_KEYS   = 3;

    // configuration register widths and reset values
    localparam int DEB_W     = 8;
    localparam int HOLD_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd5;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'b1;

    // item kinds carried in tuser
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // stream payload widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;
    localparam int EVT_W      = 2;
    localparam int LEFT_W     = 3;

    // per-key debounce phase
    typedef enum logic [1:0] {
        PH_RELEASED    = 2'd0,
        PH_DEB_PRESS   = 2'd1,
        PH_PRESSED     = 2'd2,
        PH_DEB_RELEASE = 2'd3
    } phase_t;

    // thresholds handed to every lane
    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] hold_ticks;
    } cfg_t;

    // accepted transaction kind, one-hot or idle
    typedef struct packed {
        logic tick;
        logic fetch;
    } fire_t;

endpackage

// ===== rtl/core/mkd_key_lane.sv =====
// ----------------------------------------------------------------------------
// mkd_key_lane: debounce state machine for one key
// Tracks press/release debounce, hold time and the long-press mark; pulses
// short_release on a confirmed release of a short press.
// ----------------------------------------------------------------------------
module mkd_key_lane
    import mkd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic sample_en,
    input  logic active,
    output logic short_release
);

    phase_t             phase_reg, phase_next;
    logic [DEB_W-1:0]   stable_reg, stable_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic               long_reg, long_next;

    logic [DEB_W-1:0]   stable_inc;
    logic [HOLD_W-1:0]  hold_inc;
    logic               stable_done;
    logic               hold_done;

    // saturating increments and threshold compares
    assign stable_inc  = (stable_reg == '1) ? stable_reg : stable_reg + DEB_W'(1);
    assign hold_inc    = (hold_reg == '1) ? hold_reg : hold_reg + HOLD_W'(1);
    assign stable_done = (stable_inc >= cfg.debounce_ticks);
    assign hold_done   = (hold_inc >= cfg.hold_ticks);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (sample_en) begin
            unique case (phase_reg)
                PH_RELEASED: begin
                    if (active) phase_next = PH_DEB_PRESS;
                end
                PH_DEB_PRESS: begin
                    if (!active)         phase_next = PH_RELEASED;
                    else if (stable_done) phase_next = PH_PRESSED;
                end
                PH_PRESSED: begin
                    if (!active) phase_next = PH_DEB_RELEASE;
                end
                PH_DEB_RELEASE: begin
                    if (active)           phase_next = PH_PRESSED;
                    else if (stable_done) phase_next = PH_RELEASED;
                end
                default: phase_next = PH_RELEASED;
            endcase
        end
    end

    // counters, long mark and event pulse
    always_comb begin
        stable_next   = stable_reg;
        hold_next     = hold_reg;
        long_next     = long_reg;
        short_release = 1'b0;
        if (sample_en) begin
            unique case (phase_reg)
                PH_RELEASED: begin
                    if (active) stable_next = DEB_W'(1);
                end
                PH_DEB_PRESS: begin
                    if (active) begin
                        stable_next = stable_inc;
                        if (stable_done) begin
                            hold_next = '0;
                            long_next = 1'b0;
                        end
                    end else begin
                        stable_next = '0;
                    end
                end
                PH_PRESSED: begin
                    if (active) begin
                        hold_next = hold_inc;
                        if (hold_done) long_next = 1'b1;
                    end else begin
                        stable_next = DEB_W'(1);
                    end
                end
                PH_DEB_RELEASE: begin
                    if (active) begin
                        stable_next = '0;
                    end else if (stable_done) begin
                        short_release = !long_reg;
                        stable_next   = '0;
                        hold_next     = '0;
                        long_next     = 1'b0;
                    end else begin
                        stable_next = stable_inc;
                    end
                end
                default: stable_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_RELEASED;
            stable_reg <= '0;
            hold_reg   <= '0;
            long_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            stable_reg <= stable_next;
            hold_reg   <= hold_next;
            long_reg   <= long_next;
        end
    end

endmodule

// ===== rtl/core/mkd_event_merge.sv =====
// ----------------------------------------------------------------------------
// mkd_event_merge: pending event register and fetch result stage
// Collects short-press events from all lanes, hands out the lowest pending
// key on a fetch and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module mkd_event_merge
    import mkd_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  fire_t               fire,
    input  logic [NUM_KEYS-1:0] set_mask,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [EVT_W-1:0]    event_code,
    output logic [LEFT_W-1:0]   pending_left,
    output logic                s_ready
);

    localparam int LPAD = (NUM_KEYS > LEFT_W) ? NUM_KEYS : LEFT_W;

    logic [NUM_KEYS-1:0] pending_reg, pending_next;
    logic [NUM_KEYS-1:0] lowest;
    logic [NUM_KEYS-1:0] remain;
    logic [LPAD-1:0]     remain_pad;
    logic [EVT_W-1:0]    code;
    logic                valid_reg, valid_next;
    logic [EVT_W-1:0]    code_reg;
    logic [LEFT_W-1:0]   left_reg;

    // lowest pending key, isolated as a one-hot
    assign lowest     = pending_reg & (~pending_reg + NUM_KEYS'(1));
    assign remain     = pending_reg & ~lowest;
    assign remain_pad = LPAD'(remain);

    always_comb begin
        code = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (lowest[k]) code = EVT_W'(k + 1);
        end
    end

    // pending bits: set by ticks, lowest cleared by fetches
    always_comb begin
        pending_next = pending_reg;
        if (fire.tick)       pending_next = pending_reg | set_mask;
        else if (fire.fetch) pending_next = remain;
    end

    // one-entry result register
    always_comb begin
        valid_next = valid_reg;
        if (fire.fetch)    valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire.fetch) begin
            code_reg <= code;
            left_reg <= remain_pad[LEFT_W-1:0];
        end
    end

    assign m_tvalid     = valid_reg;
    assign event_code   = code_reg;
    assign pending_left = left_reg;
    assign s_ready      = !valid_reg || m_tready;

endmodule

// ===== rtl/core/multi_key_debounce_short_press_top.sv =====
// ----------------------------------------------------------------------------
// multi_key_debounce_short_press_top: multi-key debouncer, short presses
// One debounce lane per key, a shared pending-event register and a fetch
// result stage; thresholds come from a plain write port.
//
//   channel  | dir | handshake          | contents
//   ---------+-----+--------------------+-----------------------------------
//   s_       | in  | s_tvalid/s_tready  | tuser: func; tdata: levels, read_ok
//   m_       | out | m_tvalid/m_tready  | tdata: event_code, pending_left
//   cfg_     | in  | cfg_we             | cfg_index, cfg_wdata
//
// One transaction per cycle. A tick updates each lane with its read_ok bit set
// at its accept edge; a fetch result sits in the output register from the next cycle on.
// s_tready drops only while a result is held and m_tready is low, as the
// single output register is the only buffer. Reset is synchronous and
// restores released keys, no pending events and default thresholds.
// ----------------------------------------------------------------------------
module multi_key_debounce_short_press_top
    import mkd_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] key_levels, [5:3] read_ok
    input  logic [0:0]            s_tuser,   // [0] func
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [1:0] event_code, [4:2] pending_left
);

    localparam int LPAD = (NUM_KEYS > FIELD_KEYS) ? NUM_KEYS : FIELD_KEYS;

    logic [DEB_W-1:0]    debounce_ticks_reg;
    logic [HOLD_W-1:0]   hold_ticks_reg;
    cfg_t                cfg;
    fire_t               fire;
    logic                accept;
    logic [LPAD-1:0]     levels_pad;
    logic [LPAD-1:0]     valid_pad;
    logic [NUM_KEYS-1:0] set_mask;
    logic [EVT_W-1:0]    event_code;
    logic [LEFT_W-1:0]   pending_left;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= DEB_RESET;
            hold_ticks_reg     <= HOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_ticks_reg <= cfg_wdata[DEB_W-1:0];
                CFG_HOLD:     hold_ticks_reg     <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.debounce_ticks = debounce_ticks_reg;
    assign cfg.hold_ticks     = hold_ticks_reg;

    // transaction decode; keys past the field width never sample
    assign accept     = s_tvalid && s_tready;
    assign fire.tick  = accept && (s_tuser[0] == FUNC_TICK);
    assign fire.fetch = accept && (s_tuser[0] == FUNC_FETCH);
    assign levels_pad = LPAD'(s_tdata[FIELD_KEYS-1:0]);
    assign valid_pad  = LPAD'(s_tdata[2*FIELD_KEYS-1:FIELD_KEYS]);

    // one lane per key
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        mkd_key_lane u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cfg           (cfg),
            .sample_en     (fire.tick && valid_pad[k]),
            .active        (levels_pad[k]),
            .short_release (set_mask[k])
        );
    end

    mkd_event_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .set_mask     (set_mask),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .event_code   (event_code),
        .pending_left (pending_left),
        .s_ready      (s_tready)
    );

    assign m_tdata = OUT_DATA_W'({pending_left, event_code});

endmodule

// ===== rtl/core/mkd_checker.sv =====
// ----------------------------------------------------------------------------
// mkd_checker: port-level checks for the multi-key debouncer
// Watches the stream ports for reset, stall and fetch-result consistency.
// ----------------------------------------------------------------------------
module mkd_checker
    import mkd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the output stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a blocked output stage takes no new transaction
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted with output stage full");

    // fetched key is the lowest pending one: nothing at or below it remains
    a_lowest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(((m_tdata[1:0] == 2'd1) && m_tdata[2])
                    || ((m_tdata[1:0] == 2'd2) && (m_tdata[3:2] != 2'b00))
                    || ((m_tdata[1:0] == 2'd3) && (m_tdata[4:2] != 3'b000))))
        else $error("pending bit left at or below fetched key");

    // an empty fetch leaves nothing pending
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == 2'd0) |-> (m_tdata[4:2] == 3'b000))
        else $error("empty fetch with events still pending");

endmodule

bind multi_key_debounce_short_press_top mkd_checker u_mkd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/mkd_event_checker.sv =====
// ----------------------------------------------------------------------------
// mkd_event_checker: result checker for the multi-key debouncer
// Watches the config port and both stream channels, keeps its own copy of
// the per-key debounce state and the pending short-press bits, and compares
// every fetch result with the oldest predicted one.
// ----------------------------------------------------------------------------
module mkd_event_checker
    import mkd_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] key_levels, [5:3] read_ok
    input  logic [0:0]            s_tuser,   // [0] func
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] event_code, [4:2] pending_left
    output int                    fail_count,
    output int                    outstanding,
    output int                    items_seen,
    output int                    results_seen,
    output int                    presses_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // one fetch result
    typedef struct packed {
        logic [LEFT_W-1:0] left;
        logic [EVT_W-1:0]  code;
    } key_evt_t;

    // predicted key state and thresholds
    phase_t                key_ph    [NUM_KEYS];
    logic [DEB_W-1:0]      stab_cnt  [NUM_KEYS];
    logic [HOLD_W-1:0]     held_cnt  [NUM_KEYS];
    logic                  long_flag [NUM_KEYS];
    logic [FIELD_KEYS-1:0] pend_bits;
    logic [DEB_W-1:0]      deb_thr;
    logic [HOLD_W-1:0]     hold_thr;

    key_evt_t evt_q[$];
    int       n_fail = 0;
    int       n_items = 0;
    int       n_results = 0;
    int       n_presses = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        n_fail++;
    endtask

    // one valid sample for one key
    function automatic void step_key(input int k, input logic act);
        case (key_ph[k])
            PH_RELEASED: begin
                if (act) begin
                    key_ph[k]   = PH_DEB_PRESS;
                    stab_cnt[k] = DEB_W'(1);
                end
            end
            PH_DEB_PRESS: begin
                if (act) begin
                    if (stab_cnt[k] != '1) stab_cnt[k] = stab_cnt[k] + 1'b1;
                    if (stab_cnt[k] >= deb_thr) begin
                        key_ph[k]    = PH_PRESSED;
                        held_cnt[k]  = '0;
                        long_flag[k] = 1'b0;
                    end
                end else begin
                    key_ph[k]   = PH_RELEASED;
                    stab_cnt[k] = '0;
                end
            end
            PH_PRESSED: begin
                if (act) begin
                    if (held_cnt[k] != '1) held_cnt[k] = held_cnt[k] + 1'b1;
                    if (held_cnt[k] >= hold_thr) long_flag[k] = 1'b1;
                end else begin
                    key_ph[k]   = PH_DEB_RELEASE;
                    stab_cnt[k] = DEB_W'(1);
                end
            end
            default: begin
                if (!act) begin
                    if (stab_cnt[k] != '1) stab_cnt[k] = stab_cnt[k] + 1'b1;
                    if (stab_cnt[k] >= deb_thr) begin
                        if (!long_flag[k]) pend_bits[k] = 1'b1;
                        key_ph[k]    = PH_RELEASED;
                        stab_cnt[k]  = '0;
                        held_cnt[k]  = '0;
                        long_flag[k] = 1'b0;
                    end
                end else begin
                    key_ph[k]   = PH_PRESSED;
                    stab_cnt[k] = '0;
                end
            end
        endcase
    endfunction

    // fetch: lowest pending key wins and is cleared
    function automatic key_evt_t take_press();
        key_evt_t ev;
        logic     found;
        ev.code = '0;
        found   = 1'b0;
        for (int k = 0; k < NUM_KEYS && k < FIELD_KEYS; k++) begin
            if (!found && pend_bits[k]) begin
                pend_bits[k] = 1'b0;
                ev.code      = EVT_W'(k + 1);
                found        = 1'b1;
            end
        end
        ev.left = pend_bits;
        return ev;
    endfunction

    always @(posedge aclk) begin
        key_evt_t want;
        logic [FIELD_KEYS-1:0] lv;
        logic [FIELD_KEYS-1:0] ok;
        if (!aresetn) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                key_ph[k]    = PH_RELEASED;
                stab_cnt[k]  = '0;
                held_cnt[k]  = '0;
                long_flag[k] = 1'b0;
            end
            pend_bits = '0;
            deb_thr   = DEB_RESET;
            hold_thr  = HOLD_RESET;
            evt_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_DEBOUNCE) deb_thr = cfg_wdata[DEB_W-1:0];
                else if (cfg_index == CFG_HOLD) hold_thr = cfg_wdata[HOLD_W-1:0];
            end

            // results first, so a fetch accepted this edge never matches itself
            if (m_tvalid && m_tready) begin
                n_results++;
                if (evt_q.size() == 0) begin
                    report_mismatch("result with nothing pending", int'(m_tdata), -1);
                end else begin
                    want = evt_q.pop_front();
                    if (m_tdata[1:0] != want.code)
                        report_mismatch("event_code", int'(m_tdata[1:0]), int'(want.code));
                    if (m_tdata[4:2] != want.left)
                        report_mismatch("pending_left", int'(m_tdata[4:2]), int'(want.left));
                    if (want.code != '0) n_presses++;
                end
            end

            if (s_tvalid && s_tready) begin
                n_items++;
                lv = s_tdata[2:0];
                ok = s_tdata[5:3];
                if (s_tuser[0] == FUNC_TICK) begin
                    for (int k = 0; k < NUM_KEYS && k < FIELD_KEYS; k++)
                        if (ok[k]) step_key(k, lv[k]);
                end else begin
                    evt_q.push_back(take_press());
                end
            end
        end
        fail_count   <= n_fail;
        outstanding  <= evt_q.size();
        items_seen   <= n_items;
        results_seen <= n_results;
        presses_seen <= n_presses;
    end

endmodule

// ===== sim/multi_key_debounce_short_press_top_test.sv =====
// ----------------------------------------------------------------------------
// multi_key_debounce_short_press_top_test: testbench top for the debouncer
// Drives ticks and fetches under changing thresholds and handshake pressure;
// the checker beside the block predicts and compares every fetch result.
// ----------------------------------------------------------------------------
module multi_key_debounce_short_press_top_test;
    import mkd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = FUNC_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count, outstanding, items_seen, results_seen, presses_seen;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic stall_req = 1'b0;
    int stall_left = 0;
    int cycle_cnt = 0;

    // shaping state for the random key waveforms
    int   cur_deb = int'(DEB_RESET);
    int   cur_hold = int'(HOLD_RESET);
    int   settings_run = 1;
    logic want_lv  [FIELD_KEYS];
    int   run_left [FIELD_KEYS];

    multi_key_debounce_short_press_top dut (.*);

    mkd_event_checker press_check (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, outstanding);
            $display("FAIL");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_req) begin
            m_tready   <= 1'b0;
            stall_left <= 400;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one item, with random gaps before it; returns after its accept edge
    task automatic send_item(input logic func, input logic [2:0] lv, input logic [2:0] ok);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, ok, lv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic tick(input logic [2:0] lv, input logic [2:0] ok);
        send_item(FUNC_TICK, lv, ok);
    endtask

    // fetch items carry junk in tdata, which the block ignores
    task automatic fetch();
        send_item(FUNC_FETCH, 3'($urandom), 3'($urandom));
    endtask

    // stop offering and wait until every fetch result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one register write; the caller drops cfg_we after the last one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
    endtask

    task automatic set_thresholds(input int deb, input int hold);
        settle();
        cfg_write(CFG_DEBOUNCE, deb);
        cfg_write(CFG_HOLD, hold);
        cfg_we   <= 1'b0;
        cur_deb  = deb;
        cur_hold = hold;
        settings_run++;
    endtask

    // length of the next level run: some bounces, mostly real presses
    function automatic int run_len();
        if ($urandom_range(9) < 3) return $urandom_range(1, cur_deb + 1);
        return cur_deb + 1 + $urandom_range(0, cur_hold + cur_deb + 2);
    endfunction

    // random ticks shaped as press/release runs with noise and dropped reads
    task automatic run_random(input int n, input int fetch_pct);
        logic [2:0] lv;
        logic [2:0] ok;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < fetch_pct) begin
                fetch();
            end else begin
                for (int k = 0; k < FIELD_KEYS; k++) begin
                    if (run_left[k] <= 0) begin
                        want_lv[k]  = ~want_lv[k];
                        run_left[k] = run_len();
                    end
                    run_left[k]--;
                    lv[k] = want_lv[k] ^ ($urandom_range(99) < 6);
                    ok[k] = ($urandom_range(99) >= 10);
                end
                tick(lv, ok);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < FIELD_KEYS; k++) begin
            want_lv[k]  = 1'b0;
            run_left[k] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset thresholds: key0 press, release bounce back to pressed, release
        repeat (5) tick(3'b001, 3'b001);
        tick(3'b000, 3'b001);
        tick(3'b001, 3'b001);
        repeat (5) tick(3'b000, 3'b111);
        fetch();

        // minimal debounce, short hold: all keys, skipped reads, long press
        set_thresholds(1, 2);
        tick(3'b111, 3'b111);
        tick(3'b111, 3'b111);
        tick(3'b011, 3'b111);
        tick(3'b000, 3'b110);
        tick(3'b001, 3'b001);
        tick(3'b001, 3'b001);
        tick(3'b000, 3'b001);
        tick(3'b000, 3'b001);
        tick(3'b000, 3'b010);
        tick(3'b111, 3'b000);
        repeat (3) fetch();
        // press bounce on key2
        tick(3'b100, 3'b100);
        tick(3'b000, 3'b100);

        // sender rarely idles, receiver often
        set_thresholds(3, 12);
        send_idle_pct <= 14;
        recv_idle_pct <= 64;
        run_random(70, 20);

        // long receiver hold-off while the sender keeps pushing fetches
        settle();
        stall_req <= 1'b1;
        @(posedge aclk);
        stall_req <= 1'b0;
        send_idle_pct <= 0;
        run_random(40, 50);

        // roles swapped
        set_thresholds(1, 1);
        send_idle_pct <= 64;
        recv_idle_pct <= 14;
        run_random(50, 20);

        // zero thresholds, no idling
        set_thresholds(0, 0);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_random(40, 20);

        // largest thresholds: keys 0 and 1 pass one full debounce each way
        set_thresholds(255, 65535);
        for (int i = 0; i < 520; i++) begin
            if (i % 50 == 49) fetch();
            else if (i < 260) tick({1'($urandom), 2'b11}, {1'($urandom), 2'b11});
            else tick({1'($urandom), 2'b00}, {1'($urandom), 2'b11});
        end
        repeat (3) fetch();

        settle();
        repeat (8) @(posedge aclk);
        $display("%0d items under %0d threshold settings, %0d fetch results, %0d short presses",
                 items_seen, settings_run, results_seen, presses_seen);
        $display("idle mixes on both sides and one long result-side hold-off exercised");
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
